// File: src/spwd_pkg.sv
// ----------------------------------------------------------------------------
// spwd_pkg
// Shared widths, constants and types of the servo pulse width decoder.
// ----------------------------------------------------------------------------
package spwd_pkg;

  localparam int COUNT_W    = 32;
  localparam int US_MUL_W   = 20;
  localparam int NUM_W      = COUNT_W + US_MUL_W;
  localparam int RATE_W     = 24;
  localparam int PULSE_W    = 16;
  localparam int ANGLE_W    = 11;
  localparam int ANG_PROD_W = PULSE_W + ANGLE_W;
  localparam int DIV_STEP_W = $clog2(NUM_W);
  localparam int CFG_IDX_W  = 2;

  localparam logic [US_MUL_W-1:0] US_PER_SEC = US_MUL_W'(1000000);
  localparam logic [ANGLE_W-1:0]  FULL_ANGLE = ANGLE_W'(1800);

  localparam logic [RATE_W-1:0]  RESET_TICKS_PER_SEC = RATE_W'(1000000);
  localparam logic [PULSE_W-1:0] RESET_PULSE_MIN     = PULSE_W'(1000);
  localparam logic [PULSE_W-1:0] RESET_PULSE_MAX     = PULSE_W'(2000);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TICKS_PER_SEC = 2'd0,
    CFG_PULSE_MIN     = 2'd1,
    CFG_PULSE_MAX     = 2'd2
  } cfg_reg_t;

  // Status of the shared serial divider.
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// File: src/servo_pulse_width_decoder_unit.sv
// Ticks and pin updates without a falling edge: result in the output register
// in the cycle after acceptance, one word per cycle while the output drains and
// no config write is on the port. Falling edge: up to two 52-step passes of the
// shared bit-serial divider; the next word waits until the result is registered.
// A write of either pulse limit holds off input while the angle is recomputed.
// Synchronous reset restores register defaults and clears counter, pulse and pin level.
// ----------------------------------------------------------------------------
// servo_pulse_width_decoder_unit
// Measures the high time of a servo PWM pin in timer ticks and reports the
// pulse width in microseconds and the servo angle in tenths of a degree.
// ----------------------------------------------------------------------------
module servo_pulse_width_decoder_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [7:0]                       s_axis_tdata,  // [0] pin_level
  input  logic                             s_axis_tuser,  // [0] cmd
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [31:0]                      m_axis_tdata,  // [15:0] pulse_us,
                                                          // [26:16] angle_decidegrees
  output logic                             m_axis_tuser,  // [0] pulse_updated
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [spwd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [spwd_pkg::RATE_W-1:0]      cfg_data
);

  localparam int CountW = spwd_pkg::COUNT_W;
  localparam int NumW   = spwd_pkg::NUM_W;
  localparam int RateW  = spwd_pkg::RATE_W;
  localparam int PulseW = spwd_pkg::PULSE_W;
  localparam int AngleW = spwd_pkg::ANGLE_W;
  localparam int AProdW = spwd_pkg::ANG_PROD_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_US_MUL,
    ST_US_DIV,
    ST_ANG_SETUP,
    ST_ANG_DIV,
    ST_RESULT
  } state_t;

  state_t state;

  logic [RateW-1:0]  tick_rate;
  logic [PulseW-1:0] min_width_us;
  logic [PulseW-1:0] max_width_us;
  logic              angle_stale;

  logic              previous_level;
  logic [CountW-1:0] tick_count;
  logic [PulseW-1:0] pulse_width;
  logic [AngleW-1:0] angle;
  logic              from_cfg;

  logic [NumW-1:0]   product;
  logic              div_start;
  spwd_pkg::div_stat_t div_stat;
  logic [PulseW-1:0] div_quot;
  logic              div_ovf;

  logic              out_valid;
  logic [PulseW-1:0] out_pulse;
  logic [AngleW-1:0] out_angle;
  logic              out_updated;

  logic              in_fire;
  logic              out_free;
  logic              cfg_fire;
  logic              cmd;
  logic              level;
  logic              falling;
  logic [NumW-1:0]   us_prod;
  logic [PulseW-1:0] ang_diff;
  logic [AProdW-1:0] ang_prod;
  logic [RateW-1:0]  span;

  assign cmd      = s_axis_tuser;
  assign level    = s_axis_tdata[0];
  assign falling  = cmd & ~level & previous_level;
  assign out_free = ~out_valid | m_axis_tready;

  // Items wait while a config write is on the port, but the port is always ready,
  // so a write can still land while a conversion is in flight.
  assign s_axis_tready = (state == ST_IDLE) && !angle_stale && !cfg_valid && out_free;
  assign in_fire       = s_axis_tvalid & s_axis_tready;
  assign cfg_ready     = 1'b1;
  assign cfg_fire      = cfg_valid & cfg_ready;

  assign us_prod  = NumW'(tick_count) * NumW'(spwd_pkg::US_PER_SEC);
  assign ang_diff = pulse_width - min_width_us;
  assign ang_prod = AProdW'(ang_diff) * AProdW'(spwd_pkg::FULL_ANGLE);
  assign span     = RateW'(max_width_us - min_width_us);

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_rate    <= spwd_pkg::RESET_TICKS_PER_SEC;
      min_width_us <= spwd_pkg::RESET_PULSE_MIN;
      max_width_us <= spwd_pkg::RESET_PULSE_MAX;
    end else if (cfg_fire) begin
      unique case (cfg_index)
        spwd_pkg::CFG_TICKS_PER_SEC: tick_rate    <= cfg_data;
        spwd_pkg::CFG_PULSE_MIN:     min_width_us <= cfg_data[PulseW-1:0];
        spwd_pkg::CFG_PULSE_MAX:     max_width_us <= cfg_data[PulseW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      angle_stale    <= 1'b0;
      previous_level <= 1'b0;
      tick_count     <= '0;
      pulse_width    <= '0;
      angle          <= '0;
      from_cfg       <= 1'b0;
      div_start      <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      div_start <= 1'b0;
      if (out_valid && m_axis_tready) begin
        out_valid <= 1'b0;
      end

      // A new limit invalidates the cached angle; the write wins over a clear.
      if (cfg_fire && (cfg_index == spwd_pkg::CFG_PULSE_MIN ||
                       cfg_index == spwd_pkg::CFG_PULSE_MAX)) begin
        angle_stale <= 1'b1;
      end else if (state == ST_IDLE && angle_stale) begin
        angle_stale <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (angle_stale) begin
            from_cfg <= 1'b1;
            state    <= ST_ANG_SETUP;
          end else if (in_fire) begin
            if (!cmd) begin
              if (tick_count != '1) begin
                tick_count <= tick_count + 1'b1;
              end
            end else begin
              previous_level <= level;
              if (level && !previous_level) begin
                tick_count <= '0;
              end
            end
            if (falling) begin
              from_cfg <= 1'b0;
              state    <= ST_US_MUL;
            end else begin
              out_valid   <= 1'b1;
              out_pulse   <= pulse_width;
              out_angle   <= angle;
              out_updated <= 1'b0;
            end
          end
        end
        ST_US_MUL: begin
          product <= us_prod;
          if (tick_rate == '0) begin
            pulse_width <= '0;
            state       <= ST_ANG_SETUP;
          end else begin
            div_start <= 1'b1;
            state     <= ST_US_DIV;
          end
        end
        ST_US_DIV: begin
          if (div_stat.done) begin
            pulse_width <= div_quot;
            state       <= ST_ANG_SETUP;
          end
        end
        ST_ANG_SETUP: begin
          if (max_width_us <= min_width_us || pulse_width <= min_width_us) begin
            angle <= '0;
            state <= from_cfg ? ST_IDLE : ST_RESULT;
          end else begin
            product   <= NumW'(ang_prod);
            div_start <= 1'b1;
            state     <= ST_ANG_DIV;
          end
        end
        ST_ANG_DIV: begin
          if (div_stat.done) begin
            if (div_ovf || div_quot > PulseW'(spwd_pkg::FULL_ANGLE)) begin
              angle <= spwd_pkg::FULL_ANGLE;
            end else begin
              angle <= div_quot[AngleW-1:0];
            end
            state <= from_cfg ? ST_IDLE : ST_RESULT;
          end
        end
        ST_RESULT: begin
          if (out_free) begin
            out_valid   <= 1'b1;
            out_pulse   <= pulse_width;
            out_angle   <= angle;
            out_updated <= 1'b1;
            state       <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  spwd_serdiv u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .numer    (product),
    .denom    ((state == ST_US_DIV) ? tick_rate : span),
    .stat     (div_stat),
    .quot     (div_quot),
    .quot_ovf (div_ovf)
  );

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {(32 - PulseW - AngleW)'(0), out_angle, out_pulse};
  assign m_axis_tuser  = out_updated;

`ifndef SYNTHESIS
  a_accept_idle : assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |-> state == ST_IDLE)
    else $error("word accepted while a conversion is in flight");

  a_div_done_owned : assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> (state == ST_US_DIV || state == ST_ANG_DIV))
    else $error("divider finished with no conversion waiting for it");

  a_angle_range : assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[26:16] <= spwd_pkg::FULL_ANGLE)
    else $error("angle beyond full scale");

  a_start_idle_div : assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_stat.busy)
    else $error("divider restarted while busy");
`endif

endmodule

// File: src/spwd_serdiv.sv
// ----------------------------------------------------------------------------
// spwd_serdiv
// Restoring divider that retires one quotient bit per cycle. Keeps the low
// quotient bits and flags any set bit above them.
// ----------------------------------------------------------------------------
module spwd_serdiv (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [spwd_pkg::NUM_W-1:0]   numer,
  input  logic [spwd_pkg::RATE_W-1:0]  denom,
  output spwd_pkg::div_stat_t          stat,
  output logic [spwd_pkg::PULSE_W-1:0] quot,
  output logic                         quot_ovf
);

  localparam int NumW  = spwd_pkg::NUM_W;
  localparam int RateW = spwd_pkg::RATE_W;
  localparam int QW    = spwd_pkg::PULSE_W;
  localparam int StepW = spwd_pkg::DIV_STEP_W;

  logic             busy;
  logic             done;
  logic [RateW-1:0] rem;
  logic [RateW-1:0] den;
  logic [NumW-1:0]  num;
  logic [StepW-1:0] step;
  logic [RateW:0]   trial;
  logic [RateW:0]   diff;
  logic             fits;

  // The partial remainder stays below the divisor, so a negative difference
  // always shows in the top bit.
  assign trial = {rem, num[NumW-1]};
  assign diff  = trial - {1'b0, den};
  assign fits  = ~diff[RateW];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        rem      <= '0;
        den      <= denom;
        num      <= numer;
        quot     <= '0;
        quot_ovf <= 1'b0;
        step     <= '0;
      end else if (busy) begin
        rem      <= fits ? diff[RateW-1:0] : trial[RateW-1:0];
        num      <= {num[NumW-2:0], 1'b0};
        quot     <= {quot[QW-2:0], fits};
        quot_ovf <= quot_ovf | quot[QW-1];
        step     <= step + 1'b1;
        if (step == StepW'(NumW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule
